@@ hdl/string_to_integer_parser_unit_macros.svh @@
// Assertion helpers for the string parser; clock and reset are taken
// from the module that uses them.
`ifndef STRING_TO_INTEGER_PARSER_UNIT_MACROS_SVH
`define STRING_TO_INTEGER_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define STIP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define STIP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define STIP_ASSERT_SAME(lbl, ante, cons, msg)
`define STIP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hdl/stip_pkg.sv @@
package stip_pkg;

   // Parser phases
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_WS     = 3'd1,
      PH_SIGNED = 3'd2,
      PH_ZERO   = 3'd3,
      PH_XPFX   = 3'd4,
      PH_DIGITS = 3'd5,
      PH_DONE   = 3'd6,
      PH_NODIG  = 3'd7
   } phase_type;

   // Result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NODIG   = 2'd1;
   localparam logic [1:0] ST_BADBASE = 2'd2;

   // Saturation limits of the signed 64-bit result
   localparam logic [63:0] PosLimit = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NegLimit = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [7:0] char_code;
      logic [5:0] number_base;
      logic       first;
   } req_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic [15:0]        consumed;
      logic               overflowed;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [63:0] accumulator;
      logic        negative;
      logic        overflow_seen;
      logic [5:0]  active_base;
      logic [15:0] position;
      logic [15:0] zero_end_position;
   } state_type;

endpackage

@@ hdl/string_to_integer_parser_unit.sv @@
// Each character is captured in the input register and parsed from there
// by the step logic; a terminator's result is held in the result register.
// Throughput: one character per cycle while no result waits on a stall, set by
// the combinational digit multiply-accumulate feeding the accumulator back on itself.
// Reset (synchronous, active high) clears the parser to idle and empties
// the input and result registers.
`include "string_to_integer_parser_unit_macros.svh"

module string_to_integer_parser_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stip_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stip_pkg::rsp_type rsp_data
);

   logic                in_valid_ff, in_valid_in;
   stip_pkg::req_type   in_ff, in_in;
   stip_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   stip_pkg::rsp_type   rsp_ff, rsp_in;

   stip_pkg::state_type step_state;
   stip_pkg::rsp_type   step_rsp;
   logic                step_emit;
   logic                advance;

   stip_step u_step (
      .state_i (state_ff),
      .req_i   (in_ff),
      .state_o (step_state),
      .emit_o  (step_emit),
      .rsp_o   (step_rsp)
   );

   // Advance unless a result would land on one still waiting
   assign advance   = in_valid_ff && (!step_emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Next values of the input, state and result registers
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_in        = in_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_in       = req_data;
      end
      if (advance) begin
         state_in = step_state;
      end
      if (advance && step_emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = step_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   `STIP_ASSERT_SAME(a_stall_only_when_blocked, req_stall, rsp_valid_ff && rsp_stall, "input stalled without a waiting result")
   `STIP_ASSERT_NEXT(a_idle_after_term, advance && step_emit, state_ff.phase == stip_pkg::PH_IDLE, "parser not idle after terminator")
   `STIP_ASSERT_SAME(a_status_code, rsp_valid_ff, rsp_ff.status == stip_pkg::ST_OK || rsp_ff.status == stip_pkg::ST_NODIG || rsp_ff.status == stip_pkg::ST_BADBASE, "undefined status code")
   `STIP_ASSERT_SAME(a_fail_is_zero, rsp_valid_ff && rsp_ff.status != stip_pkg::ST_OK, rsp_ff.value == 64'sd0 && rsp_ff.consumed == 16'd0 && !rsp_ff.overflowed, "failed parse carries data")
   `STIP_ASSERT_SAME(a_overflow_saturates, rsp_valid_ff && rsp_ff.overflowed, rsp_ff.value == $signed(stip_pkg::PosLimit) || rsp_ff.value == $signed(stip_pkg::NegLimit), "overflow without saturated value")

endmodule

@@ hdl/stip_step.sv @@
module stip_step (
   input  stip_pkg::state_type state_i,
   input  stip_pkg::req_type   req_i,
   output stip_pkg::state_type state_o,
   output logic                emit_o,
   output stip_pkg::rsp_type   rsp_o
);

   localparam logic [7:0] CharNul    = 8'h00;
   localparam logic [7:0] CharSpace  = 8'h20;
   localparam logic [7:0] CharTab    = 8'h09;
   localparam logic [7:0] CharCr     = 8'h0D;
   localparam logic [7:0] CharPlus   = 8'h2B;
   localparam logic [7:0] CharMinus  = 8'h2D;
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperX = 8'h58;
   localparam logic [7:0] CharUpperZ = 8'h5A;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharLowerX = 8'h78;
   localparam logic [7:0] CharLowerZ = 8'h7A;
   localparam logic [5:0] NoDigit    = 6'd63;
   localparam logic [5:0] BaseMin    = 6'd2;
   localparam logic [5:0] BaseMax    = 6'd36;
   localparam logic [5:0] BaseOct    = 6'd8;
   localparam logic [5:0] BaseDec    = 6'd10;
   localparam logic [5:0] BaseHex    = 6'd16;
   localparam logic [15:0] CountMax  = 16'hFFFF;

   function automatic logic [5:0] digit_of(input logic [7:0] c);
      logic [7:0] t;
      begin
         t = 8'd0;
         if (c >= CharZero && c <= CharNine) begin
            t = c - CharZero;
         end else if (c >= CharLowerA && c <= CharLowerZ) begin
            t = c - CharLowerA + 8'd10;
         end else if (c >= CharUpperA && c <= CharUpperZ) begin
            t = c - CharUpperA + 8'd10;
         end else begin
            t = {2'b00, NoDigit};
         end
         digit_of = t[5:0];
      end
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == CharSpace) || (c >= CharTab && c <= CharCr);
   endfunction

   function automatic logic base_bad(input logic [5:0] b);
      base_bad = (b != 6'd0) && ((b < BaseMin) || (b > BaseMax));
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      sat_inc = (v == CountMax) ? CountMax : v + 16'd1;
   endfunction

   stip_pkg::state_type nx;
   logic [7:0]  c;
   logic [5:0]  d;
   logic        active;
   logic        fdone;
   logic        take;
   logic [69:0] prod;
   logic [63:0] lim;
   logic [63:0] mag;
   logic [15:0] end_pos;

   assign c = req_i.char_code;
   assign d = digit_of(req_i.char_code);

   // Advance the parser by one character
   always_comb begin
      nx      = state_i;
      active  = 1'b0;
      fdone   = 1'b0;
      take    = 1'b0;
      emit_o  = 1'b0;
      rsp_o   = '0;
      prod    = '0;
      lim     = '0;
      mag     = '0;
      end_pos = '0;

      // Open a new string and latch its base
      if (req_i.first) begin
         nx             = '0;
         nx.active_base = req_i.number_base;
         nx.phase       = base_bad(req_i.number_base) ? stip_pkg::PH_NODIG
                                                      : stip_pkg::PH_WS;
         active         = 1'b1;
      end else if (state_i.phase != stip_pkg::PH_IDLE) begin
         active = 1'b1;
      end

      if (active && c == CharNul) begin
         // Terminator: build the transaction and close the string
         emit_o = 1'b1;
         if (base_bad(nx.active_base)) begin
            rsp_o.status = stip_pkg::ST_BADBASE;
         end else if (nx.phase == stip_pkg::PH_ZERO || nx.phase == stip_pkg::PH_XPFX) begin
            rsp_o.consumed = nx.zero_end_position;
            rsp_o.status   = stip_pkg::ST_OK;
         end else if (nx.phase == stip_pkg::PH_DIGITS || nx.phase == stip_pkg::PH_DONE) begin
            end_pos = (nx.phase == stip_pkg::PH_DIGITS) ? nx.position
                                                        : nx.zero_end_position;
            if (nx.overflow_seen) begin
               mag = nx.negative ? stip_pkg::NegLimit : stip_pkg::PosLimit;
            end else begin
               mag = nx.negative ? (64'd0 - nx.accumulator) : nx.accumulator;
            end
            rsp_o.value      = $signed(mag);
            rsp_o.consumed   = end_pos;
            rsp_o.overflowed = nx.overflow_seen;
            rsp_o.status     = stip_pkg::ST_OK;
         end else begin
            rsp_o.status = stip_pkg::ST_NODIG;
         end
         nx.phase = stip_pkg::PH_IDLE;
      end else if (active) begin
         // Skip whitespace and take the sign
         if (nx.phase == stip_pkg::PH_WS) begin
            if (is_space(c)) begin
               fdone = 1'b1;
            end else if (c == CharMinus) begin
               nx.negative = 1'b1;
               nx.phase    = stip_pkg::PH_SIGNED;
               fdone       = 1'b1;
            end else if (c == CharPlus) begin
               nx.phase = stip_pkg::PH_SIGNED;
               fdone    = 1'b1;
            end else begin
               nx.phase = stip_pkg::PH_SIGNED;
            end
         end

         // First character after the sign
         if (!fdone && nx.phase == stip_pkg::PH_SIGNED) begin
            fdone = 1'b1;
            if (c == CharZero) begin
               nx.zero_end_position = sat_inc(nx.position);
               nx.phase             = stip_pkg::PH_ZERO;
            end else begin
               if (nx.active_base == 6'd0) begin
                  nx.active_base = BaseDec;
               end
               if (d < nx.active_base) begin
                  nx.accumulator = '0;
                  nx.phase       = stip_pkg::PH_DIGITS;
                  take           = 1'b1;
               end else begin
                  nx.phase = stip_pkg::PH_NODIG;
               end
            end
         end

         // Leading zero: look for the hex prefix
         if (!fdone && nx.phase == stip_pkg::PH_ZERO) begin
            if ((nx.active_base == 6'd0 || nx.active_base == BaseHex) &&
                (c == CharLowerX || c == CharUpperX)) begin
               nx.active_base = BaseHex;
               nx.phase       = stip_pkg::PH_XPFX;
               fdone          = 1'b1;
            end else begin
               if (nx.active_base == 6'd0) begin
                  nx.active_base = BaseOct;
               end
               nx.accumulator = '0;
               nx.phase       = stip_pkg::PH_DIGITS;
            end
         end else if (!fdone && nx.phase == stip_pkg::PH_XPFX) begin
            nx.accumulator = '0;
            fdone          = 1'b1;
            if (d < BaseHex) begin
               nx.phase = stip_pkg::PH_DIGITS;
               take     = 1'b1;
            end else begin
               nx.phase = stip_pkg::PH_DONE;
            end
         end

         // Digit run
         if (!fdone && nx.phase == stip_pkg::PH_DIGITS) begin
            if (d < nx.active_base) begin
               take = 1'b1;
            end else begin
               nx.zero_end_position = nx.position;
               nx.phase             = stip_pkg::PH_DONE;
            end
         end

         // Accumulate one digit, saturating past the signed limit
         if (take && nx.active_base >= BaseMin) begin
            prod = 70'(nx.accumulator) * 70'(nx.active_base) + 70'(d);
            lim  = nx.negative ? stip_pkg::NegLimit : stip_pkg::PosLimit;
            if (nx.overflow_seen || prod > 70'(lim)) begin
               nx.overflow_seen = 1'b1;
            end else begin
               nx.accumulator = prod[63:0];
            end
         end

         nx.position = sat_inc(nx.position);
      end

      state_o = nx;
   end

endmodule
